// File: hw/rtl/tse_pkg.sv
`timescale 1ns / 1ps

package tse_pkg;

    localparam int LEN_W       = 16;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // tls framing constants
    localparam logic [7:0] TLS_HANDSHAKE   = 8'h16;
    localparam logic [7:0] TLS_MAJOR       = 8'h03;
    localparam logic [7:0] HS_CLIENT_HELLO = 8'h01;
    localparam logic [7:0] NAME_HOST       = 8'h00;
    localparam logic [15:0] EXT_SNI        = 16'h0000;
    localparam logic [15:0] HELLO_FIXED    = 16'd34;   // version + random
    localparam logic [15:0] MIN_PKT        = 16'd9;
    localparam logic [15:0] MIN_SNI_EXT    = 16'd5;

    typedef enum logic [1:0] {
        ST_NAME  = 2'd0,
        ST_NONE  = 2'd1,
        ST_TRUNC = 2'd2
    } status_t;

    typedef enum logic [4:0] {
        PH_IDLE,
        PH_HDR,
        PH_RANDOM,
        PH_SID_LEN,
        PH_SID,
        PH_CS_HI,
        PH_CS_LO,
        PH_CS,
        PH_CM_LEN,
        PH_CM,
        PH_EXT_HI,
        PH_EXT_LO,
        PH_ET_HI,
        PH_ET_LO,
        PH_EL_HI,
        PH_EL_LO,
        PH_EXT_BODY,
        PH_NL_HI,
        PH_NL_LO,
        PH_NT,
        PH_NN_HI,
        PH_NN_LO,
        PH_NAME_SKIP,
        PH_EMIT,
        PH_DONE,
        PH_FAIL
    } phase_t;

    typedef struct packed {
        logic [7:0] name_byte;
        status_t    status;
        logic       result_last;
    } result_t;

endpackage

// File: hw/rtl/tse_pkt_if.sv
`timescale 1ns / 1ps

interface tse_pkt_if;
    logic        valid;
    logic        ready;
    logic [7:0]  data_byte;
    logic        first_byte;
    logic        last_byte;
    logic [15:0] packet_length;

    modport source (output valid, data_byte, first_byte, last_byte, packet_length,
                    input ready);
    modport sink (input valid, data_byte, first_byte, last_byte, packet_length,
                  output ready);
endinterface

// File: hw/rtl/tse_res_if.sv
`timescale 1ns / 1ps

interface tse_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] name_byte;
    logic [1:0] status;
    logic       result_last;

    modport source (output valid, name_byte, status, result_last, input ready);
    modport sink (input valid, name_byte, status, result_last, output ready);
endinterface

// File: hw/rtl/tse_parser.sv
`timescale 1ns / 1ps

module tse_parser (
    input  logic             clk,
    input  logic             rst_n,
    tse_pkt_if.sink          pkt,
    output logic             res_valid,
    input  logic             res_ready,
    output tse_pkg::result_t res_data
);
    import tse_pkg::*;

    phase_t            phase_reg, phase_next, ph_cur;
    logic [LEN_W-1:0]  pos_reg, pos_next, pos_cur;
    logic [LEN_W-1:0]  field_reg, field_next, field_cur, field_dec;
    logic [LEN_W-1:0]  ext_end_reg, ext_end_next, ext_end_cur;
    logic [LEN_W-1:0]  nl_end_reg, nl_end_next, nl_end_cur;
    logic [LEN_W-1:0]  ext_rem_reg, ext_rem_next, ext_rem_cur, ext_rem_dec;
    logic [LEN_W-1:0]  total_reg, total_next, total_cur;
    logic [LEN_W-1:0]  hold_reg, hold_next, hold_cur;
    logic              sni_reg, sni_next, sni_cur;
    logic              host_reg, host_next, host_cur;

    logic              accept, active, has_res, emit, fin;
    logic [7:0]        b;
    logic [LEN_W:0]    q, q_sum;
    logic [LEN_W-1:0]  len16;
    logic [23:0]       len24;

    function automatic logic fits(logic [LEN_W:0] at, logic [23:0] need,
                                  logic [LEN_W-1:0] lim);
        logic [24:0] s;
        s = {{(24-LEN_W){1'b0}}, at} + {1'b0, need};
        return s <= {{(25-LEN_W){1'b0}}, lim};
    endfunction

    function automatic phase_t ext_loop(logic [LEN_W:0] at, logic [LEN_W-1:0] ee);
        return fits(at, 24'd4, ee) ? PH_ET_HI : PH_FAIL;
    endfunction

    function automatic phase_t name_loop(logic [LEN_W:0] at, logic [LEN_W-1:0] nle,
                                         logic [LEN_W-1:0] er, logic [LEN_W-1:0] ee);
        phase_t r;
        if (fits(at, 24'd3, nle))
        begin
            r = PH_NT;
        end
        else if (er == '0)
        begin
            r = ext_loop(at, ee);
        end
        else
        begin
            r = PH_EXT_BODY;
        end
        return r;
    endfunction

    function automatic logic [7:0] to_lower(logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
    endfunction

    assign b        = pkt.data_byte;
    assign pkt.ready = res_ready;
    assign accept   = pkt.valid && res_ready;
    assign active   = pkt.first_byte || (phase_reg != PH_IDLE);

    // a first beat restarts the parse at the record header (or fails a packet shorter than MIN_PKT)
    always_comb
    begin
        if (pkt.first_byte)
        begin
            ph_cur      = (pkt.packet_length < MIN_PKT) ? PH_FAIL : PH_HDR;
            pos_cur     = '0;
            field_cur   = '0;
            ext_end_cur = '0;
            nl_end_cur  = '0;
            ext_rem_cur = '0;
            total_cur   = pkt.packet_length;
            hold_cur    = '0;
            sni_cur     = 1'b0;
            host_cur    = 1'b0;
        end
        else
        begin
            ph_cur      = phase_reg;
            pos_cur     = pos_reg;
            field_cur   = field_reg;
            ext_end_cur = ext_end_reg;
            nl_end_cur  = nl_end_reg;
            ext_rem_cur = ext_rem_reg;
            total_cur   = total_reg;
            hold_cur    = hold_reg;
            sni_cur     = sni_reg;
            host_cur    = host_reg;
        end
    end

    assign q           = {1'b0, pos_cur} + 1'b1;
    assign len16       = {hold_cur[7:0], b};
    assign len24       = {hold_cur, b};
    assign q_sum       = q + {1'b0, len16};
    assign field_dec   = (field_cur != '0) ? field_cur - 1'b1 : '0;
    assign ext_rem_dec = (ext_rem_cur != '0) ? ext_rem_cur - 1'b1 : '0;

    // next state
    always_comb
    begin
        phase_next   = ph_cur;
        field_next   = field_cur;
        ext_end_next = ext_end_cur;
        nl_end_next  = nl_end_cur;
        ext_rem_next = ext_rem_cur;
        total_next   = total_cur;
        hold_next    = hold_cur;
        sni_next     = sni_cur;
        host_next    = host_cur;

        unique case (ph_cur)
            PH_HDR:
            begin
                priority if (pos_cur == 16'd0 && b != TLS_HANDSHAKE)
                begin
                    phase_next = PH_FAIL;
                end
                else if (pos_cur == 16'd1 && b != TLS_MAJOR)
                begin
                    phase_next = PH_FAIL;
                end
                else if (pos_cur == 16'd3 || pos_cur == 16'd6)
                begin
                    hold_next = {8'h00, b};
                end
                else if (pos_cur == 16'd4)
                begin
                    if (!fits(17'd5, len24, total_cur))
                    begin
                        phase_next = PH_FAIL;
                    end
                end
                else if (pos_cur == 16'd5 && b != HS_CLIENT_HELLO)
                begin
                    phase_next = PH_FAIL;
                end
                else if (pos_cur == 16'd7)
                begin
                    hold_next = len16;
                end
                else if (pos_cur == 16'd8)
                begin
                    if (!fits(17'd9, len24, total_cur) ||
                        !fits(17'd9, {8'h00, HELLO_FIXED}, total_cur))
                    begin
                        phase_next = PH_FAIL;
                    end
                    else
                    begin
                        field_next = HELLO_FIXED;
                        phase_next = PH_RANDOM;
                    end
                end
                else
                begin
                    phase_next = ph_cur;
                end
            end
            PH_RANDOM:
            begin
                field_next = field_dec;
                if (field_dec == '0)
                begin
                    phase_next = fits(q, 24'd1, total_cur) ? PH_SID_LEN : PH_FAIL;
                end
            end
            PH_SID_LEN, PH_CM_LEN:
            begin
                if (!fits(q, {16'h0000, b}, total_cur))
                begin
                    phase_next = PH_FAIL;
                end
                else if (b == 8'h00)
                begin
                    phase_next = fits(q, 24'd2, total_cur) ?
                                 ((ph_cur == PH_SID_LEN) ? PH_CS_HI : PH_EXT_HI) : PH_FAIL;
                end
                else
                begin
                    field_next = {8'h00, b};
                    phase_next = (ph_cur == PH_SID_LEN) ? PH_SID : PH_CM;
                end
            end
            PH_SID, PH_CM:
            begin
                field_next = field_dec;
                if (field_dec == '0)
                begin
                    phase_next = fits(q, 24'd2, total_cur) ?
                                 ((ph_cur == PH_SID) ? PH_CS_HI : PH_EXT_HI) : PH_FAIL;
                end
            end
            PH_CS_HI, PH_EXT_HI, PH_ET_HI, PH_EL_HI:
            begin
                hold_next  = {8'h00, b};
                phase_next = phase_t'(ph_cur + 5'd1);
            end
            PH_CS_LO:
            begin
                if (!fits(q, {8'h00, len16}, total_cur))
                begin
                    phase_next = PH_FAIL;
                end
                else if (len16 == '0)
                begin
                    phase_next = fits(q, 24'd1, total_cur) ? PH_CM_LEN : PH_FAIL;
                end
                else
                begin
                    field_next = len16;
                    phase_next = PH_CS;
                end
            end
            PH_CS:
            begin
                field_next = field_dec;
                if (field_dec == '0)
                begin
                    phase_next = fits(q, 24'd1, total_cur) ? PH_CM_LEN : PH_FAIL;
                end
            end
            PH_EXT_LO:
            begin
                if (!fits(q, {8'h00, len16}, total_cur))
                begin
                    phase_next = PH_FAIL;
                end
                else
                begin
                    ext_end_next = q_sum[LEN_W-1:0];
                    phase_next   = ext_loop(q, q_sum[LEN_W-1:0]);
                end
            end
            PH_ET_LO:
            begin
                sni_next   = (len16 == EXT_SNI);
                phase_next = PH_EL_HI;
            end
            PH_EL_LO:
            begin
                if (!fits(q, {8'h00, len16}, ext_end_cur))
                begin
                    phase_next = PH_FAIL;
                end
                else
                begin
                    ext_rem_next = len16;
                    priority if (sni_cur)
                    begin
                        phase_next = (len16 < MIN_SNI_EXT) ? PH_FAIL : PH_NL_HI;
                    end
                    else if (len16 == '0)
                    begin
                        phase_next = ext_loop(q, ext_end_cur);
                    end
                    else
                    begin
                        phase_next = PH_EXT_BODY;
                    end
                end
            end
            PH_EXT_BODY:
            begin
                ext_rem_next = ext_rem_dec;
                if (ext_rem_dec == '0)
                begin
                    phase_next = ext_loop(q, ext_end_cur);
                end
            end
            PH_NL_HI, PH_NN_HI:
            begin
                ext_rem_next = ext_rem_dec;
                hold_next    = {8'h00, b};
                phase_next   = phase_t'(ph_cur + 5'd1);
            end
            PH_NL_LO:
            begin
                ext_rem_next = ext_rem_dec;
                if (len16 > ext_rem_dec)
                begin
                    phase_next = PH_FAIL;
                end
                else
                begin
                    nl_end_next = q_sum[LEN_W-1:0];
                    phase_next  = name_loop(q, q_sum[LEN_W-1:0], ext_rem_dec, ext_end_cur);
                end
            end
            PH_NT:
            begin
                ext_rem_next = ext_rem_dec;
                host_next    = (b == NAME_HOST);
                phase_next   = PH_NN_HI;
            end
            PH_NN_LO:
            begin
                ext_rem_next = ext_rem_dec;
                priority if (!fits(q, {8'h00, len16}, nl_end_cur))
                begin
                    phase_next = PH_FAIL;
                end
                else if (host_cur && len16 != '0)
                begin
                    field_next = len16;
                    phase_next = PH_EMIT;
                end
                else if (len16 == '0)
                begin
                    phase_next = name_loop(q, nl_end_cur, ext_rem_dec, ext_end_cur);
                end
                else
                begin
                    field_next = len16;
                    phase_next = PH_NAME_SKIP;
                end
            end
            PH_NAME_SKIP:
            begin
                ext_rem_next = ext_rem_dec;
                field_next   = field_dec;
                if (field_dec == '0)
                begin
                    phase_next = name_loop(q, nl_end_cur, ext_rem_dec, ext_end_cur);
                end
            end
            PH_EMIT:
            begin
                field_next = field_dec;
                if (field_dec == '0)
                begin
                    phase_next = PH_DONE;
                end
            end
            default:
            begin
                phase_next = ph_cur;
            end
        endcase

        if (pkt.last_byte)
        begin
            phase_next = PH_IDLE;
        end
        pos_next = q[LEN_W] ? '1 : q[LEN_W-1:0];
    end

    // result for this beat
    always_comb
    begin
        emit    = (ph_cur == PH_EMIT);
        fin     = (field_dec == '0);
        has_res = active && (emit || (pkt.last_byte && ph_cur != PH_DONE));
        res_data.name_byte   = 8'h00;
        res_data.status      = ST_NONE;
        res_data.result_last = 1'b1;
        if (emit && !(pkt.last_byte && !fin))
        begin
            res_data.name_byte   = to_lower(b);
            res_data.status      = ST_NAME;
            res_data.result_last = fin;
        end
        else if (emit)
        begin
            res_data.status = ST_TRUNC;
        end
    end

    assign res_valid = accept && has_res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            pos_reg     <= '0;
            field_reg   <= '0;
            ext_end_reg <= '0;
            nl_end_reg  <= '0;
            ext_rem_reg <= '0;
            total_reg   <= '0;
            hold_reg    <= '0;
            sni_reg     <= 1'b0;
            host_reg    <= 1'b0;
        end
        else if (accept && active)
        begin
            phase_reg   <= phase_next;
            pos_reg     <= pos_next;
            field_reg   <= field_next;
            ext_end_reg <= ext_end_next;
            nl_end_reg  <= nl_end_next;
            ext_rem_reg <= ext_rem_next;
            total_reg   <= total_next;
            hold_reg    <= hold_next;
            sni_reg     <= sni_next;
            host_reg    <= host_next;
        end
    end

endmodule

// File: hw/rtl/tse_queue.sv
`timescale 1ns / 1ps

module tse_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  tse_pkg::result_t push_data,
    tse_res_if.source        res
);
    import tse_pkg::*;

    result_t             mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic                do_push, do_pop;
    result_t             head;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign do_push    = push_valid && push_ready;
    assign do_pop     = res.valid && res.ready;

    assign head            = mem[rd_ptr_reg];
    assign res.valid       = (count_reg != '0);
    assign res.name_byte   = head.name_byte;
    assign res.status      = head.status;
    assign res.result_last = head.result_last;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

// File: hw/rtl/tls_sni_extractor_unit.sv
`timescale 1ns / 1ps

// channel  dir  beat contents
// -------  ---  ----------------------------------------------------
// pkt      in   data_byte, first_byte, last_byte, packet_length
// res      out  name_byte, status, result_last
//
// one payload byte per cycle while the result queue has room; the parser decides a beat in the cycle it is taken
// a result is written into a 4-beat queue as its byte is taken and reaches res from the queue head
// pkt stalls only while that queue is full; res may stall freely
// rst_n clears the parser to idle and empties the queue

module tls_sni_extractor_unit (
    input  logic      clk,
    input  logic      rst_n,
    tse_pkt_if.sink   pkt,
    tse_res_if.source res
);
    import tse_pkg::*;

    logic    push_valid;
    logic    push_ready;
    result_t push_data;

    tse_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .pkt       (pkt),
        .res_valid (push_valid),
        .res_ready (push_ready),
        .res_data  (push_data)
    );

    tse_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .res        (res)
    );

endmodule
